### sv/segint_pkg.sv
// Shared constants and types for the segment intersection block.
// No dependencies; used by every module of the block.
package segint_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // width of a crossing coordinate on the result channel
    localparam int OUT_W = 48;
    localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // setup stage plus one stage per quotient bit
    localparam int DIV_LAT = OUT_W + 1;

    typedef struct packed {
        logic full;
        logic empty;
    } segint_qstat_t;

endpackage

### sv/segint_front.sv
// Front part: accepts an item, forms determinant, numerators and the
// scaled crossing numerators over five stages. Depends on segint_pkg.
module segint_front #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_BITS-1:0]      a_start_x,
    input  logic signed [COORD_BITS-1:0]      a_start_y,
    input  logic signed [COORD_BITS-1:0]      a_end_x,
    input  logic signed [COORD_BITS-1:0]      a_end_y,
    input  logic signed [COORD_BITS-1:0]      b_start_x,
    input  logic signed [COORD_BITS-1:0]      b_start_y,
    input  logic signed [COORD_BITS-1:0]      b_end_x,
    input  logic signed [COORD_BITS-1:0]      b_end_y,
    input  segint_pkg::segint_qstat_t         qstat,
    output logic                              push,
    output logic signed [3*COORD_BITS+3:0]    push_nx,
    output logic signed [3*COORD_BITS+3:0]    push_ny,
    output logic signed [2*COORD_BITS+2:0]    push_den,
    output logic                              push_par,
    output logic                              push_onb
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int PW  = 2*C + 2;
    localparam int KW  = 2*C + 3;
    localparam int L   = C + 2;
    localparam int MPW = 2*C + 4;
    localparam int NXW = 3*C + 4;

    logic fe;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: differences
    logic signed [C-1:0]  x1_1_reg, y1_1_reg;
    logic signed [DW-1:0] dx12_reg, dy12_reg, dx34_reg, dy34_reg, dx13_reg, dy13_reg;
    // stage 2: products
    logic signed [C-1:0]  x1_2_reg, y1_2_reg;
    logic signed [DW-1:0] dx12_2_reg, dy12_2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    // stage 3: determinant and numerators
    logic signed [C-1:0]  x1_3_reg, y1_3_reg;
    logic signed [DW-1:0] dx21_reg, dy21_reg;
    logic signed [KW-1:0] den_3_reg, tnum_reg, unum_reg;
    // stage 4: partial products, split at bit L
    logic signed [MPW-1:0] xdh_reg, xdl_reg, xth_reg, xtl_reg;
    logic signed [MPW-1:0] ydh_reg, ydl_reg, yth_reg, ytl_reg;
    logic signed [KW-1:0]  den_4_reg;
    logic                  par_4_reg, onb_4_reg;
    // stage 5: crossing numerators
    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic signed [KW-1:0]  den_5_reg;
    logic                  par_5_reg, onb_5_reg;

    logic signed [C:0]     den_hi, tnum_hi;
    logic signed [L:0]     den_lo, tnum_lo;

    function automatic logic in_unit(input logic signed [KW-1:0] num,
                                     input logic signed [KW-1:0] den);
        logic res;
        if (den > 0)
            res = (num >= 0) && (num <= den);
        else
            res = (num <= 0) && (num >= den);
        return res;
    endfunction

    assign fe       = !(v5_reg && qstat.full);
    assign in_stall = !fe;

    assign den_hi  = $signed(den_3_reg[KW-1:L]);
    assign tnum_hi = $signed(tnum_reg[KW-1:L]);
    assign den_lo  = $signed({1'b0, den_3_reg[L-1:0]});
    assign tnum_lo = $signed({1'b0, tnum_reg[L-1:0]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (fe)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe)
        begin
            x1_1_reg <= a_start_x;
            y1_1_reg <= a_start_y;
            dx12_reg <= DW'(a_start_x) - DW'(a_end_x);
            dy12_reg <= DW'(a_start_y) - DW'(a_end_y);
            dx34_reg <= DW'(b_start_x) - DW'(b_end_x);
            dy34_reg <= DW'(b_start_y) - DW'(b_end_y);
            dx13_reg <= DW'(a_start_x) - DW'(b_start_x);
            dy13_reg <= DW'(a_start_y) - DW'(b_start_y);

            x1_2_reg   <= x1_1_reg;
            y1_2_reg   <= y1_1_reg;
            dx12_2_reg <= dx12_reg;
            dy12_2_reg <= dy12_reg;
            p1_reg     <= PW'(dx12_reg) * PW'(dy34_reg);
            p2_reg     <= PW'(dy12_reg) * PW'(dx34_reg);
            p3_reg     <= PW'(dx13_reg) * PW'(dy34_reg);
            p4_reg     <= PW'(dy13_reg) * PW'(dx34_reg);
            p5_reg     <= PW'(dy12_reg) * PW'(dx13_reg);
            p6_reg     <= PW'(dx12_reg) * PW'(dy13_reg);

            x1_3_reg  <= x1_2_reg;
            y1_3_reg  <= y1_2_reg;
            dx21_reg  <= -dx12_2_reg;
            dy21_reg  <= -dy12_2_reg;
            den_3_reg <= KW'(p1_reg) - KW'(p2_reg);
            tnum_reg  <= KW'(p3_reg) - KW'(p4_reg);
            unum_reg  <= KW'(p5_reg) - KW'(p6_reg);

            xdh_reg   <= MPW'(x1_3_reg) * MPW'(den_hi);
            xdl_reg   <= MPW'(x1_3_reg) * MPW'(den_lo);
            xth_reg   <= MPW'(dx21_reg) * MPW'(tnum_hi);
            xtl_reg   <= MPW'(dx21_reg) * MPW'(tnum_lo);
            ydh_reg   <= MPW'(y1_3_reg) * MPW'(den_hi);
            ydl_reg   <= MPW'(y1_3_reg) * MPW'(den_lo);
            yth_reg   <= MPW'(dy21_reg) * MPW'(tnum_hi);
            ytl_reg   <= MPW'(dy21_reg) * MPW'(tnum_lo);
            den_4_reg <= den_3_reg;
            par_4_reg <= (den_3_reg == '0);
            onb_4_reg <= in_unit(tnum_reg, den_3_reg) && in_unit(unum_reg, den_3_reg);

            nx_reg    <= ((NXW'(xdh_reg) + NXW'(xth_reg)) << L)
                         + NXW'(xdl_reg) + NXW'(xtl_reg);
            ny_reg    <= ((NXW'(ydh_reg) + NXW'(yth_reg)) << L)
                         + NXW'(ydl_reg) + NXW'(ytl_reg);
            den_5_reg <= den_4_reg;
            par_5_reg <= par_4_reg;
            onb_5_reg <= onb_4_reg;
        end
    end

    assign push     = v5_reg && !qstat.full;
    assign push_nx  = nx_reg;
    assign push_ny  = ny_reg;
    assign push_den = den_5_reg;
    assign push_par = par_5_reg;
    assign push_onb = onb_5_reg;

endmodule

### sv/segint_queue.sv
// Short FIFO between front and back parts.
// Depends on segint_pkg for the status struct.
module segint_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = segint_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      pop,
    output logic [WIDTH-1:0]          rd_data,
    output segint_pkg::segint_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(DEPTH - 1))
            res = '0;
        else
            res = p + 1'b1;
        return res;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ptr_inc(wp_reg);
            if (pop)
                rp_reg <= ptr_inc(rp_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wr_data;
    end

    assign rd_data     = mem[rp_reg];
    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> cnt_reg != CNT_W'(DEPTH))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue read while empty");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

### sv/segint_div.sv
// Pipelined restoring divider: |num| * 2^FRAC_BITS / |den|, one quotient
// bit per stage, with overflow precheck. Depends on segint_pkg.
module segint_div #(
    parameter int NUM_W     = 52,
    parameter int DEN_W     = 35,
    parameter int FRAC_BITS = segint_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [NUM_W-1:0]         num,
    input  logic signed [DEN_W-1:0]         den,
    output logic [segint_pkg::OUT_W-1:0]    quo,
    output logic                            ovf,
    output logic                            neg
);

    localparam int OW = segint_pkg::OUT_W;
    localparam int MW = DEN_W;
    localparam int SW = NUM_W + FRAC_BITS;
    localparam int HW = (SW > OW) ? SW - OW : 1;
    localparam int EW = OW + HW;
    localparam int CW = (HW > MW) ? HW : MW;

    logic [NUM_W-1:0] nmag;
    logic [MW-1:0]    dmag;
    logic [EW-1:0]    shifted;
    logic [HW-1:0]    head;

    // remainder, and the dividend bits still to go shifted against quotient bits
    logic [MW-1:0] r_reg   [0:OW];
    logic [OW-1:0] qn_reg  [0:OW];
    logic [MW-1:0] d_reg   [0:OW];
    logic          ovf_reg [0:OW];
    logic          neg_reg [0:OW];

    assign nmag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign dmag    = den[DEN_W-1] ? MW'(-den) : MW'(den);
    assign shifted = EW'(nmag) << FRAC_BITS;
    assign head    = shifted[EW-1:OW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= MW'(head);
            qn_reg[0]  <= shifted[OW-1:0];
            d_reg[0]   <= dmag;
            ovf_reg[0] <= (CW'(head) >= CW'(dmag));
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
        end
    end

    for (genvar k = 1; k <= OW; k++)
    begin : g_stage
        logic [MW:0]   trial;
        logic          ge;
        logic [MW-1:0] r_next;

        assign trial  = {r_reg[k-1], qn_reg[k-1][OW-1]};
        assign ge     = (trial >= {1'b0, d_reg[k-1]});
        assign r_next = ge ? MW'(trial - {1'b0, d_reg[k-1]}) : MW'(trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= r_next;
                qn_reg[k]  <= {qn_reg[k-1][OW-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign quo = qn_reg[OW];
    assign ovf = ovf_reg[OW];
    assign neg = neg_reg[OW];

endmodule

### sv/segint_back.sv
// Back part: pops queue items, divides both crossing numerators by the
// determinant, clamps and registers the result. Depends on segint_pkg, segint_div.
module segint_back #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  segint_pkg::segint_qstat_t               qstat,
    output logic                                    pop,
    input  logic signed [3*COORD_BITS+3:0]          nx,
    input  logic signed [3*COORD_BITS+3:0]          ny,
    input  logic signed [2*COORD_BITS+2:0]          den,
    input  logic                                    par,
    input  logic                                    onb,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    parallel,
    output logic                                    on_both_segments,
    output logic                                    saturated,
    output logic signed [segint_pkg::OUT_W-1:0]     cross_x,
    output logic signed [segint_pkg::OUT_W-1:0]     cross_y
);

    localparam int OW  = segint_pkg::OUT_W;
    localparam int LAT = segint_pkg::DIV_LAT;
    localparam int NXW = 3*COORD_BITS + 4;
    localparam int KW  = 2*COORD_BITS + 3;

    logic          be;
    logic          sb_valid_reg [0:LAT-1];
    logic          sb_par_reg   [0:LAT-1];
    logic          sb_onb_reg   [0:LAT-1];

    logic [OW-1:0] qx, qy;
    logic          ovfx, ovfy, negx, negy;
    logic [OW-1:0] resx, resy;
    logic          satx, saty;

    logic          out_valid_reg, par_reg, onb_reg, sat_reg;
    logic [OW-1:0] cx_reg, cy_reg;

    function automatic logic [OW:0] finish(input logic [OW-1:0] q,
                                           input logic ovf, input logic negq);
        logic [OW-1:0] lim;
        logic          sat;
        logic [OW-1:0] mag;
        lim = negq ? segint_pkg::OUT_NEG_MAX : segint_pkg::OUT_POS_MAX;
        sat = ovf || (q > lim);
        mag = sat ? lim : q;
        return {sat, negq ? OW'(-mag) : mag};
    endfunction

    assign be  = !out_valid_reg || !out_stall;
    assign pop = be && !qstat.empty;

    segint_div #(
        .NUM_W     (NXW),
        .DEN_W     (KW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_x (
        .clk (clk),
        .en  (be),
        .num (nx),
        .den (den),
        .quo (qx),
        .ovf (ovfx),
        .neg (negx)
    );

    segint_div #(
        .NUM_W     (NXW),
        .DEN_W     (KW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div_y (
        .clk (clk),
        .en  (be),
        .num (ny),
        .den (den),
        .quo (qy),
        .ovf (ovfy),
        .neg (negy)
    );

    assign {satx, resx} = finish(qx, ovfx, negx);
    assign {saty, resy} = finish(qy, ovfy, negy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                sb_valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (be)
        begin
            sb_valid_reg[0] <= pop;
            for (int i = 1; i < LAT; i++)
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            out_valid_reg <= sb_valid_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            sb_par_reg[0] <= par;
            sb_onb_reg[0] <= onb;
            for (int i = 1; i < LAT; i++)
            begin
                sb_par_reg[i] <= sb_par_reg[i-1];
                sb_onb_reg[i] <= sb_onb_reg[i-1];
            end
            par_reg <= sb_par_reg[LAT-1];
            // zero determinant: everything but the flag reads zero
            onb_reg <= !sb_par_reg[LAT-1] && sb_onb_reg[LAT-1];
            sat_reg <= !sb_par_reg[LAT-1] && (satx || saty);
            cx_reg  <= sb_par_reg[LAT-1] ? '0 : resx;
            cy_reg  <= sb_par_reg[LAT-1] ? '0 : resy;
        end
    end

    assign out_valid        = out_valid_reg;
    assign parallel         = par_reg;
    assign on_both_segments = onb_reg;
    assign saturated        = sat_reg;
    assign cross_x          = $signed(cx_reg);
    assign cross_y          = $signed(cy_reg);

`ifndef SYNTHESIS
    a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && par_reg) |-> (cx_reg == '0 && cy_reg == '0 && !sat_reg && !onb_reg))
        else $error("parallel result with nonzero fields");
`endif

endmodule

### sv/segment_intersection.sv
// Top level of the 2D segment intersection block.
// Depends on segint_pkg, segint_front, segint_queue, segint_back.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    a_start_x .. b_end_y (COORD_BITS each)
//   result    out_valid / out_stall  parallel, on_both_segments, saturated,
//                                    cross_x, cross_y
//
// One item per cycle sustained while out_stall is low; one result per item, in order.
// Registers on the path: 5 front stages, 1 queue slot, 49 divider stages
// (setup plus one per quotient bit), 1 output register.
// A 4-entry queue lets the front keep accepting while the back is held.
// in_stall rises only when the front's last stage waits on a full queue.
// Reset clears valids and queue pointers; no clearing pass.
module segment_intersection #(
    parameter int COORD_BITS = segint_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = segint_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS-1:0]        a_start_x,
    input  logic signed [COORD_BITS-1:0]        a_start_y,
    input  logic signed [COORD_BITS-1:0]        a_end_x,
    input  logic signed [COORD_BITS-1:0]        a_end_y,
    input  logic signed [COORD_BITS-1:0]        b_start_x,
    input  logic signed [COORD_BITS-1:0]        b_start_y,
    input  logic signed [COORD_BITS-1:0]        b_end_x,
    input  logic signed [COORD_BITS-1:0]        b_end_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                parallel,
    output logic                                on_both_segments,
    output logic                                saturated,
    output logic signed [segint_pkg::OUT_W-1:0] cross_x,
    output logic signed [segint_pkg::OUT_W-1:0] cross_y
);

    localparam int NXW = 3*COORD_BITS + 4;
    localparam int KW  = 2*COORD_BITS + 3;
    localparam int QW  = 2*NXW + KW + 2;

    segint_pkg::segint_qstat_t qstat;
    logic                  push, pop;
    logic signed [NXW-1:0] f_nx, f_ny, b_nx, b_ny;
    logic signed [KW-1:0]  f_den, b_den;
    logic                  f_par, f_onb, b_par, b_onb;
    logic [QW-1:0]         q_wr, q_rd;

    segint_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .qstat     (qstat),
        .push      (push),
        .push_nx   (f_nx),
        .push_ny   (f_ny),
        .push_den  (f_den),
        .push_par  (f_par),
        .push_onb  (f_onb)
    );

    assign q_wr = {f_nx, f_ny, f_den, f_par, f_onb};

    segint_queue #(
        .WIDTH (QW),
        .DEPTH (segint_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr),
        .pop     (pop),
        .rd_data (q_rd),
        .qstat   (qstat)
    );

    assign b_nx  = $signed(q_rd[QW-1 -: NXW]);
    assign b_ny  = $signed(q_rd[QW-NXW-1 -: NXW]);
    assign b_den = $signed(q_rd[KW+1:2]);
    assign b_par = q_rd[1];
    assign b_onb = q_rd[0];

    segint_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .qstat            (qstat),
        .pop              (pop),
        .nx               (b_nx),
        .ny               (b_ny),
        .den              (b_den),
        .par              (b_par),
        .onb              (b_onb),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .parallel         (parallel),
        .on_both_segments (on_both_segments),
        .saturated        (saturated),
        .cross_x          (cross_x),
        .cross_y          (cross_y)
    );

endmodule
